### rtl/core/kdac_pkg.sv
// Shared types, constants and helpers for the keypad-disarmed alarm controller.
// Used by every module in rtl/core; has no dependencies of its own.
package kdac_pkg;

  localparam int CODE_LENGTH = 4;
  localparam int KEY_IDX_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam logic [7:0] KEY_NONE  = 8'd0;
  localparam logic [7:0] KEY_ENTER = 8'd35;
  localparam logic [7:0] KEY_RESET_CHAR = 8'd48;

  localparam logic [2:0] WRONG_SAT = 3'd7;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_UNLOCK_CODE   = 3'd0,
    REG_OVER_TEMP     = 3'd1,
    REG_TICK_MS       = 3'd2,
    REG_BLINK_BOTH    = 3'd3,
    REG_BLINK_GAS     = 3'd4,
    REG_BLINK_TEMP    = 3'd5,
    REG_MAX_WRONG     = 3'd6
  } reg_idx_t;

  localparam logic [31:0]       RST_UNLOCK_CODE = 32'd825765941;
  localparam logic signed [8:0] RST_OVER_TEMP   = 9'sd50;
  localparam logic [9:0]        RST_TICK_MS     = 10'd10;
  localparam logic [15:0]       RST_BLINK_BOTH  = 16'd100;
  localparam logic [15:0]       RST_BLINK_GAS   = 16'd1000;
  localparam logic [15:0]       RST_BLINK_TEMP  = 16'd500;
  localparam logic [2:0]        RST_MAX_WRONG   = 3'd5;

  typedef struct packed {
    logic [31:0]       unlock_code;
    logic signed [8:0] trip_temp;
    logic [9:0]        tick_ms;
    logic [15:0]       blink_both_ms;
    logic [15:0]       blink_gas_ms;
    logic [15:0]       blink_temp_ms;
    logic [2:0]        max_wrong;
  } kdac_cfg_t;

  // Keypad status toward the top level and the alarm unit.
  typedef struct packed {
    logic disarm;        // code matched on this tick
    logic incorrect_q;   // incorrect LED before this tick
    logic incorrect;     // incorrect LED after this tick
    logic blocked_q;     // blocked LED before this tick
    logic blocked;       // blocked LED after this tick
  } kdac_kp_stat_t;

  // Expected key at ring position i; positions beyond the fourth expect zero.
  function automatic logic [7:0] code_key(input logic [31:0] code, input int i);
    int sh;
    sh = 8 * (CODE_LENGTH - 1 - i);
    if (sh >= 32 || sh < 0) begin
      return 8'd0;
    end
    return code[sh +: 8];
  endfunction

endpackage

### rtl/core/kdac_cfg.sv
// Configuration register file for the alarm controller.
// Depends on kdac_pkg for register indexes, reset values and the config struct.
module kdac_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [2:0]               wr_index,
  input  logic [31:0]              wr_data,
  output kdac_pkg::kdac_cfg_t      cfg
);

  kdac_pkg::kdac_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_code     <= kdac_pkg::RST_UNLOCK_CODE;
      cfg_r.trip_temp       <= kdac_pkg::RST_OVER_TEMP;
      cfg_r.tick_ms         <= kdac_pkg::RST_TICK_MS;
      cfg_r.blink_both_ms   <= kdac_pkg::RST_BLINK_BOTH;
      cfg_r.blink_gas_ms    <= kdac_pkg::RST_BLINK_GAS;
      cfg_r.blink_temp_ms   <= kdac_pkg::RST_BLINK_TEMP;
      cfg_r.max_wrong       <= kdac_pkg::RST_MAX_WRONG;
    end else if (wr_en) begin
      case (wr_index)
        kdac_pkg::REG_UNLOCK_CODE: cfg_r.unlock_code     <= wr_data;
        kdac_pkg::REG_OVER_TEMP:   cfg_r.trip_temp       <= $signed(wr_data[8:0]);
        kdac_pkg::REG_TICK_MS:     cfg_r.tick_ms         <= wr_data[9:0];
        kdac_pkg::REG_BLINK_BOTH:  cfg_r.blink_both_ms   <= wr_data[15:0];
        kdac_pkg::REG_BLINK_GAS:   cfg_r.blink_gas_ms    <= wr_data[15:0];
        kdac_pkg::REG_BLINK_TEMP:  cfg_r.blink_temp_ms   <= wr_data[15:0];
        kdac_pkg::REG_MAX_WRONG:   cfg_r.max_wrong       <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/kdac_blink.sv
// Alarm source latching and LED blink timer for the alarm controller.
// Depends on kdac_pkg for the configuration struct.
module kdac_blink (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     gas_present,
  input  logic signed [8:0]        temperature_c,
  input  logic                     disarm,
  input  kdac_pkg::kdac_cfg_t      cfg,
  output logic                     armed_now,
  output logic                     alarm_nxt,
  output logic                     led_nxt
);

  logic        alarm_r;
  logic        gas_lat_r;
  logic        temp_lat_r;
  logic [15:0] elapsed_r;
  logic        led_r;

  logic        gas_lat_nxt;
  logic        temp_lat_nxt;
  logic [15:0] elapsed_nxt;
  logic        over_temp;
  logic [16:0] sum;
  logic [15:0] sat;
  logic [15:0] period;
  logic        have_period;

  assign over_temp = temperature_c > cfg.trip_temp;
  assign armed_now = alarm_r | over_temp | gas_present;
  assign sum       = {1'b0, elapsed_r} + {7'd0, cfg.tick_ms};
  assign sat       = sum[16] ? 16'hFFFF : sum[15:0];

  always_comb begin
    gas_lat_nxt  = gas_lat_r | gas_present;
    temp_lat_nxt = temp_lat_r | over_temp;
    period       = 16'd0;
    have_period  = 1'b1;
    if (gas_lat_nxt && temp_lat_nxt) begin
      period = cfg.blink_both_ms;
    end else if (gas_lat_nxt) begin
      period = cfg.blink_gas_ms;
    end else if (temp_lat_nxt) begin
      period = cfg.blink_temp_ms;
    end else begin
      have_period = 1'b0;
    end

    elapsed_nxt = elapsed_r;
    led_nxt     = led_r;
    if (armed_now) begin
      elapsed_nxt = sat;
      if (have_period && sat >= period) begin
        elapsed_nxt = 16'd0;
        led_nxt     = ~led_r;
      end
    end else begin
      led_nxt      = 1'b0;
      gas_lat_nxt  = 1'b0;
      temp_lat_nxt = 1'b0;
    end
    alarm_nxt = armed_now & ~disarm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r    <= 1'b0;
      gas_lat_r  <= 1'b0;
      temp_lat_r <= 1'b0;
      elapsed_r  <= 16'd0;
      led_r      <= 1'b0;
    end else if (en) begin
      alarm_r    <= alarm_nxt;
      gas_lat_r  <= gas_lat_nxt;
      temp_lat_r <= temp_lat_nxt;
      elapsed_r  <= elapsed_nxt;
      led_r      <= led_nxt;
    end
  end

endmodule

### rtl/core/kdac_keypad.sv
// Keypad code entry, compare and wrong-attempt blocking for the alarm controller.
// Depends on kdac_pkg for the configuration struct, key codes and code_key().
module kdac_keypad (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [7:0]               key_char,
  input  logic                     armed_now,
  input  kdac_pkg::kdac_cfg_t      cfg,
  output kdac_pkg::kdac_kp_stat_t  stat
);

  logic [7:0]                     keys_r [kdac_pkg::CODE_LENGTH];
  logic [kdac_pkg::KEY_IDX_W-1:0] pos_r;
  logic [2:0]                     wrong_r;
  logic                           ind_r;
  logic                           press_r;
  logic                           blocked_r;

  logic [kdac_pkg::KEY_IDX_W-1:0] pos_nxt;
  logic [2:0]                     wrong_nxt;
  logic                           ind_nxt;
  logic                           press_nxt;
  logic                           blocked_nxt;
  logic                           key_wr;
  logic                           match;
  logic                           disarm;
  logic                           is_enter;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < kdac_pkg::CODE_LENGTH; i++) begin
      if (keys_r[i] != kdac_pkg::code_key(cfg.unlock_code, i)) begin
        match = 1'b0;
      end
    end
  end

  assign is_enter = key_char == kdac_pkg::KEY_ENTER;

  always_comb begin
    pos_nxt     = pos_r;
    wrong_nxt   = wrong_r;
    ind_nxt     = ind_r;
    press_nxt   = press_r;
    blocked_nxt = blocked_r;
    key_wr      = 1'b0;
    disarm      = 1'b0;
    if (wrong_r < cfg.max_wrong) begin
      if (key_char != kdac_pkg::KEY_NONE && !is_enter) begin
        key_wr = 1'b1;
        if (pos_r == kdac_pkg::KEY_IDX_W'(kdac_pkg::CODE_LENGTH - 1)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (is_enter) begin
        if (ind_r) begin
          if (press_r) begin
            ind_nxt   = 1'b0;
            press_nxt = 1'b0;
            pos_nxt   = '0;
          end else begin
            press_nxt = 1'b1;
          end
        end else if (armed_now) begin
          if (match) begin
            disarm    = 1'b1;
            wrong_nxt = 3'd0;
            pos_nxt   = '0;
          end else begin
            ind_nxt = 1'b1;
            if (wrong_r < kdac_pkg::WRONG_SAT) begin
              wrong_nxt = wrong_r + 3'd1;
            end
          end
        end
      end
    end else begin
      blocked_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kdac_pkg::CODE_LENGTH; i++) begin
        keys_r[i] <= kdac_pkg::KEY_RESET_CHAR;
      end
      pos_r     <= '0;
      wrong_r   <= 3'd0;
      ind_r     <= 1'b0;
      press_r   <= 1'b0;
      blocked_r <= 1'b0;
    end else if (en) begin
      if (key_wr) begin
        keys_r[pos_r] <= key_char;
      end
      pos_r     <= pos_nxt;
      wrong_r   <= wrong_nxt;
      ind_r     <= ind_nxt;
      press_r   <= press_nxt;
      blocked_r <= blocked_nxt;
    end
  end

  assign stat.disarm      = disarm;
  assign stat.incorrect_q = ind_r;
  assign stat.incorrect   = ind_nxt;
  assign stat.blocked_q   = blocked_r;
  assign stat.blocked     = blocked_nxt;

endmodule

### rtl/core/keypad_disarmed_alarm_controller.sv
// Top level of the keypad-disarmed gas and over-temperature alarm controller.
// Depends on kdac_pkg, kdac_cfg, kdac_blink and kdac_keypad.
//
// Each input transfer is one tick carrying the gas flag, the temperature and
// the key released in that tick; each tick produces exactly one result transfer
// with the alarm state and the three LED levels as they stand after the tick.
// A tick is captured in an input register and processed combinationally on
// its way into the result register, so one tick per clock is sustained. The
// only limit on rate is the result side: when the result register is full
// and stalled, the tick in the input register waits, and the input stalls
// once that register is also occupied. Configuration registers are written
// through the cfg_ channel, which is always ready; writes are meant to happen
// while no tick is in flight. There is no clearing pass after reset.
module keypad_disarmed_alarm_controller (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_gas_present,
  input  logic signed [8:0] in_temperature_c,
  input  logic [7:0]        in_key_char,

  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_alarm_active,
  output logic              out_alarm_led,
  output logic              out_incorrect_led,
  output logic              out_blocked_led,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  kdac_pkg::kdac_cfg_t     cfg;
  kdac_pkg::kdac_kp_stat_t kp_stat;

  // Input register stage.
  logic              s1_valid_r;
  logic              s1_gas_r;
  logic signed [8:0] s1_temp_r;
  logic [7:0]        s1_key_r;

  // Result register stage.
  logic out_valid_r;
  logic out_alarm_r;
  logic out_led_r;
  logic out_incorrect_r;
  logic out_blocked_r;

  logic in_accept;
  logic adv;
  logic armed_now;
  logic alarm_nxt;
  logic led_nxt;

  // The tick in the input register is processed when the result register can
  // take its result; all state updates happen on this same edge.
  assign adv       = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~adv;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept | (s1_valid_r & ~adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_gas_r  <= in_gas_present;
      s1_temp_r <= in_temperature_c;
      s1_key_r  <= in_key_char;
    end
  end

  kdac_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // Sources and blinking are evaluated first; the keypad sees the armed state
  // after source latching and may then disarm within the same tick.
  kdac_blink u_blink (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .gas_present   (s1_gas_r),
    .temperature_c (s1_temp_r),
    .disarm        (kp_stat.disarm),
    .cfg           (cfg),
    .armed_now     (armed_now),
    .alarm_nxt     (alarm_nxt),
    .led_nxt       (led_nxt)
  );

  kdac_keypad u_keypad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .key_char  (s1_key_r),
    .armed_now (armed_now),
    .cfg       (cfg),
    .stat      (kp_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_alarm_r     <= alarm_nxt;
      out_led_r       <= led_nxt;
      out_incorrect_r <= kp_stat.incorrect;
      out_blocked_r   <= kp_stat.blocked;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alarm_active  = out_alarm_r;
  assign out_alarm_led     = out_led_r;
  assign out_incorrect_led = out_incorrect_r;
  assign out_blocked_led   = out_blocked_r;

  // Once the keypad is blocked it stays blocked until reset.
  a_blocked_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    kp_stat.blocked_q |-> kp_stat.blocked)
    else $error("blocked indicator cleared without reset");

  // The incorrect LED can only light on an enter key of a processed tick.
  a_incorrect_on_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !kp_stat.incorrect_q && kp_stat.incorrect) |->
      (s1_key_r == kdac_pkg::KEY_ENTER))
    else $error("incorrect LED lit without an enter key");

  // The input side only stalls while a tick is held in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with no tick waiting");

endmodule

### tb/tb_keypad_disarmed_alarm_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for keypad_disarmed_alarm_controller: directed and
// random tick traffic, checked against an in-bench model of the alarm logic.
// Depends on kdac_pkg and the RTL under rtl/core.
module tb_keypad_disarmed_alarm_controller;

  // Cycles without any transfer before the run is declared hung. This is generous
  // against the slowest legal stretch of random stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  // Drain time after the last result: input register plus result register, with margin.
  localparam int DRAIN_CYCLES   = 4;

  typedef struct packed {
    logic alarm_active;
    logic alarm_led;
    logic incorrect_led;
    logic blocked_led;
  } status_t;

  logic              clk               = 1'b0;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_stall;
  logic              in_gas_present    = 1'b0;
  logic signed [8:0] in_temperature_c  = '0;
  logic [7:0]        in_key_char       = kdac_pkg::KEY_NONE;
  logic              out_valid;
  logic              out_stall         = 1'b0;
  logic              out_alarm_active;
  logic              out_alarm_led;
  logic              out_incorrect_led;
  logic              out_blocked_led;
  logic              cfg_valid         = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index         = '0;
  logic [31:0]       cfg_wdata         = '0;

  keypad_disarmed_alarm_controller uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_gas_present    (in_gas_present),
    .in_temperature_c  (in_temperature_c),
    .in_key_char       (in_key_char),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_alarm_active  (out_alarm_active),
    .out_alarm_led     (out_alarm_led),
    .out_incorrect_led (out_incorrect_led),
    .out_blocked_led   (out_blocked_led),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Chance in percent that the sender leaves a cycle empty, and that the
  // receiver stalls a cycle. One random phase sets both to zero.
  int sender_gap_pct     = 29;
  int receiver_stall_pct = 29;

  int fail_count   = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;

  // Status words predicted for accepted ticks, oldest first.
  status_t expected_status[$];

  // ---------------------------------------------------------------------------
  // Shadow of the configuration registers, updated on each register transfer.
  // ---------------------------------------------------------------------------
  logic [31:0]       code_q;
  logic signed [8:0] trip_level;
  logic [9:0]        tick_len;
  logic [15:0]       period_both;
  logic [15:0]       period_gas;
  logic [15:0]       period_temp;
  logic [2:0]        wrong_limit;

  // ---------------------------------------------------------------------------
  // Model state of the alarm, the blink timer and the keypad.
  // ---------------------------------------------------------------------------
  logic       armed;
  logic       gas_seen;
  logic       heat_seen;
  logic [15:0] blink_ms;
  logic       led_on;
  logic [7:0] typed_keys [kdac_pkg::CODE_LENGTH];
  int         key_slot;
  logic [2:0] wrong_tries;
  logic       incorrect_on;
  logic       enter_once;
  logic       lockout;

  function automatic void reset_model();
    code_q      = kdac_pkg::RST_UNLOCK_CODE;
    trip_level  = kdac_pkg::RST_OVER_TEMP;
    tick_len    = kdac_pkg::RST_TICK_MS;
    period_both = kdac_pkg::RST_BLINK_BOTH;
    period_gas  = kdac_pkg::RST_BLINK_GAS;
    period_temp = kdac_pkg::RST_BLINK_TEMP;
    wrong_limit = kdac_pkg::RST_MAX_WRONG;
    armed        = 1'b0;
    gas_seen     = 1'b0;
    heat_seen    = 1'b0;
    blink_ms     = '0;
    led_on       = 1'b0;
    for (int i = 0; i < kdac_pkg::CODE_LENGTH; i++) typed_keys[i] = kdac_pkg::KEY_RESET_CHAR;
    key_slot     = 0;
    wrong_tries  = '0;
    incorrect_on = 1'b0;
    enter_once   = 1'b0;
    lockout      = 1'b0;
  endfunction

  // Advances the model by one tick and returns the status after it. Sensors
  // and the blink timer are updated before the keypad, so a disarm leaves the
  // LED at its level until the following tick.
  function automatic status_t predict_status(input logic gas,
                                             input logic signed [8:0] temp,
                                             input logic [7:0] key);
    int          elapsed;
    logic [15:0] period;
    logic        have_src;
    logic        hit;
    status_t     st;
    if (temp > trip_level) begin
      heat_seen = 1'b1;
      armed     = 1'b1;
    end
    if (gas) begin
      gas_seen = 1'b1;
      armed    = 1'b1;
    end

    if (armed) begin
      // The timer saturates rather than wrapping.
      elapsed = blink_ms + tick_len;
      if (elapsed > 65535) elapsed = 65535;
      have_src = 1'b1;
      period   = '0;
      if (gas_seen && heat_seen) period = period_both;
      else if (gas_seen) period = period_gas;
      else if (heat_seen) period = period_temp;
      else have_src = 1'b0;
      if (have_src && elapsed >= period) begin
        elapsed = 0;
        led_on  = ~led_on;
      end
      blink_ms = elapsed[15:0];
    end else begin
      // Disarmed: LED dark and sources forgotten, but the timer keeps its value.
      led_on    = 1'b0;
      gas_seen  = 1'b0;
      heat_seen = 1'b0;
    end

    if (wrong_tries < wrong_limit) begin
      if (key != kdac_pkg::KEY_NONE && key != kdac_pkg::KEY_ENTER) begin
        typed_keys[key_slot] = key;
        key_slot = (key_slot + 1) % kdac_pkg::CODE_LENGTH;
      end
      if (key == kdac_pkg::KEY_ENTER) begin
        if (incorrect_on) begin
          // Two enter presses acknowledge a wrong code.
          if (enter_once) begin
            incorrect_on = 1'b0;
            enter_once   = 1'b0;
            key_slot     = 0;
          end else begin
            enter_once = 1'b1;
          end
        end else if (armed) begin
          hit = 1'b1;
          for (int i = 0; i < kdac_pkg::CODE_LENGTH; i++)
            if (typed_keys[i] != code_q[8*(kdac_pkg::CODE_LENGTH-1-i) +: 8]) hit = 1'b0;
          if (hit) begin
            armed       = 1'b0;
            wrong_tries = '0;
            key_slot    = 0;
          end else begin
            incorrect_on = 1'b1;
            if (wrong_tries < kdac_pkg::WRONG_SAT) wrong_tries = wrong_tries + 3'd1;
          end
        end
      end
    end else begin
      lockout = 1'b1;
    end

    st.alarm_active  = armed;
    st.alarm_led     = led_on;
    st.incorrect_led = incorrect_on;
    st.blocked_led   = lockout;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the result check and the watchdog. Outputs are
  // sampled at the rising edge before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else if (out_valid && !out_stall) begin
        got.alarm_active  = out_alarm_active;
        got.alarm_led     = out_alarm_led;
        got.incorrect_led = out_incorrect_led;
        got.blocked_led   = out_blocked_led;
        if (expected_status.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (got.alarm_active !== want.alarm_active) begin
            $error("alarm_active: expected %0b, got %0b", want.alarm_active, got.alarm_active);
            fail_count++;
          end
          if (got.alarm_led !== want.alarm_led) begin
            $error("alarm_led: expected %0b, got %0b", want.alarm_led, got.alarm_led);
            fail_count++;
          end
          if (got.incorrect_led !== want.incorrect_led) begin
            $error("incorrect_led: expected %0b, got %0b",
                   want.incorrect_led, got.incorrect_led);
            fail_count++;
          end
          if (got.blocked_led !== want.blocked_led) begin
            $error("blocked_led: expected %0b, got %0b", want.blocked_led, got.blocked_led);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // One tick transfer. Valid stays high from one tick into the next unless a
  // random gap is taken, and the payload holds while the block stalls.
  task automatic send_tick(input logic gas, input int temp, input logic [7:0] key);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_gas_present   <= gas;
    in_temperature_c <= temp[8:0];
    in_key_char      <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status.push_back(predict_status(gas, temp[8:0], key));
    items_sent++;
  endtask

  // Sender holds off until every result is back, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; the caller lowers cfg_valid after the last one so that a
  // burst of writes keeps valid high throughout.
  task automatic write_reg(input kdac_pkg::reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      kdac_pkg::REG_UNLOCK_CODE: code_q      = data;
      kdac_pkg::REG_OVER_TEMP:   trip_level  = data[8:0];
      kdac_pkg::REG_TICK_MS:     tick_len    = data[9:0];
      kdac_pkg::REG_BLINK_BOTH:  period_both = data[15:0];
      kdac_pkg::REG_BLINK_GAS:   period_gas  = data[15:0];
      kdac_pkg::REG_BLINK_TEMP:  period_temp = data[15:0];
      kdac_pkg::REG_MAX_WRONG:   wrong_limit = data[2:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] code, input int level, input int tick,
                             input int both_ms, input int gas_ms, input int temp_ms,
                             input int limit);
    wait_idle();
    write_reg(kdac_pkg::REG_UNLOCK_CODE, code);
    write_reg(kdac_pkg::REG_OVER_TEMP,   level);
    write_reg(kdac_pkg::REG_TICK_MS,     tick);
    write_reg(kdac_pkg::REG_BLINK_BOTH,  both_ms);
    write_reg(kdac_pkg::REG_BLINK_GAS,   gas_ms);
    write_reg(kdac_pkg::REG_BLINK_TEMP,  temp_ms);
    write_reg(kdac_pkg::REG_MAX_WRONG,   limit);
    cfg_valid <= 1'b0;
  endtask

  // Any key that the keypad stores: neither "no key" nor enter.
  function automatic logic [7:0] any_key_byte();
    logic [7:0] k;
    do k = 8'($urandom_range(1, 255)); while (k == kdac_pkg::KEY_ENTER);
    return k;
  endfunction

  function automatic logic [31:0] random_code();
    return {any_key_byte(), any_key_byte(), any_key_byte(), any_key_byte()};
  endfunction

  function automatic int any_temp();
    return int'($urandom_range(0, 205)) - 55;
  endfunction

  // A reading at or below the threshold, which never arms the alarm.
  function automatic int quiet_temp();
    int lvl;
    lvl = trip_level;
    return int'($urandom_range(0, lvl + 55)) - 55;
  endfunction

  // A reading above the threshold; only called when one exists.
  function automatic int hot_temp();
    int lvl;
    lvl = trip_level;
    return lvl + 1 + int'($urandom_range(0, 149 - lvl));
  endfunction

  task automatic quiet_tick(input logic [7:0] key);
    send_tick(1'b0, quiet_temp(), key);
  endtask

  // Arms the alarm from gas, heat or both; heat is impossible at the top level.
  task automatic arm_tick();
    int src;
    src = $urandom_range(0, 2);
    if (trip_level >= 9'sd150) src = 0;
    send_tick(src != 1, (src == 0) ? quiet_temp() : hot_temp(), kdac_pkg::KEY_NONE);
  endtask

  task automatic clear_incorrect();
    if (incorrect_on) repeat (2) quiet_tick(kdac_pkg::KEY_ENTER);
  endtask

  // Types a code and presses enter. The code is first aligned to the
  // start of the key ring with filler keys, which may wrap the ring.
  task automatic type_code(input bit correct);
    while (key_slot != 0 && wrong_tries < wrong_limit) quiet_tick(any_key_byte());
    for (int i = 0; i < kdac_pkg::CODE_LENGTH; i++)
      quiet_tick(correct ? code_q[8*(kdac_pkg::CODE_LENGTH-1-i) +: 8] : any_key_byte());
    quiet_tick(kdac_pkg::KEY_ENTER);
  endtask

  // One alarm episode: arm, acknowledge an old wrong code, let the LED blink
  // with some noise mixed in, then try a code (mostly the right one).
  task automatic run_episode();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) arm_tick();
    clear_incorrect();
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_tick(1'($urandom_range(0, 1)), any_temp(), 8'($urandom_range(0, 255)));
      else
        quiet_tick(kdac_pkg::KEY_NONE);
    end
    type_code($urandom_range(0, 3) != 0);
    n = $urandom_range(0, 3);
    repeat (n) quiet_tick(kdac_pkg::KEY_NONE);
  endtask

  // Runs episodes for about the given number of ticks. Halfway through, the
  // sender pauses until every outstanding result has come back.
  task automatic run_traffic_phase(input int items);
    int stop_at;
    bit paused;
    stop_at = items_sent + items;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      run_episode();
      if (!paused && items_sent >= stop_at - items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset configuration: field extremes, enter while disarmed, a reading equal
  // to the threshold, a wrong code and its two-press acknowledge, a ring wrap
  // and a disarm that leaves the LED lit for one more tick.
  task automatic test_directed_keypad();
    send_tick(1'b0, -55, kdac_pkg::KEY_NONE);
    send_tick(1'b0, 50, kdac_pkg::KEY_ENTER);
    send_tick(1'b0, 150, 8'hFF);
    send_tick(1'b1, -1, kdac_pkg::KEY_NONE);
    quiet_tick(8'h01);
    quiet_tick(8'h80);
    quiet_tick(8'h7F);
    quiet_tick(8'h55);
    quiet_tick(kdac_pkg::KEY_ENTER);
    quiet_tick(kdac_pkg::KEY_ENTER);
    quiet_tick(kdac_pkg::KEY_ENTER);
    quiet_tick(8'hAA);
    quiet_tick(8'h33);
    type_code(1'b1);
    quiet_tick(kdac_pkg::KEY_NONE);
  endtask

  // A zero blink period toggles the LED on every armed tick.
  task automatic test_zero_blink_period();
    load_config(code_q, 50, 10, 0, 0, 0, 5);
    send_tick(1'b1, 20, kdac_pkg::KEY_NONE);
    repeat (3) quiet_tick(kdac_pkg::KEY_NONE);
    send_tick(1'b0, 100, kdac_pkg::KEY_NONE);
    repeat (2) quiet_tick(kdac_pkg::KEY_NONE);
    clear_incorrect();
    type_code(1'b1);
    quiet_tick(kdac_pkg::KEY_NONE);
  endtask

  // A 1000 ms tick against the longest period: the timer runs into its ceiling.
  task automatic test_timer_saturation();
    load_config(code_q, 50, 1000, 65535, 65535, 65535, 5);
    send_tick(1'b0, 120, kdac_pkg::KEY_NONE);
    repeat (70) quiet_tick(kdac_pkg::KEY_NONE);
    clear_incorrect();
    type_code(1'b1);
    quiet_tick(kdac_pkg::KEY_NONE);
  endtask

  // Random episodes under several settings, register extremes among them.
  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_config(random_code(), any_temp(), $urandom_range(1, 1000),
                       $urandom_range(1, 2000), $urandom_range(1, 2000),
                       $urandom_range(1, 2000), 7);
        1: load_config(random_code(), -55, 1, 1, 1, 1, 7);
        2: begin
          // Back-to-back traffic with no gaps and no stalls.
          sender_gap_pct     = 0;
          receiver_stall_pct = 0;
          load_config(32'hFFFF_FFFF, 150, 1000, 65535, 65535, 65535, 7);
        end
        3: load_config(random_code(), any_temp(), $urandom_range(1, 1000),
                       $urandom_range(1, 65535), $urandom_range(1, 65535),
                       $urandom_range(1, 65535), $urandom_range(2, 7));
        default: load_config(random_code(), any_temp(), $urandom_range(1, 100),
                             $urandom_range(1, 500), $urandom_range(1, 500),
                             $urandom_range(1, 500), $urandom_range(3, 7));
      endcase
      run_traffic_phase(100);
      sender_gap_pct     = 29;
      receiver_stall_pct = 29;
    end
  endtask

  // One wrong code blocks at a limit of one; raising the limit reopens the
  // keypad but the blocked LED stays; a limit of zero blocks at once.
  task automatic test_wrong_code_blocking();
    load_config(code_q, 50, 10, 100, 1000, 500, 7);
    arm_tick();
    clear_incorrect();
    type_code(1'b1);
    load_config(code_q, 50, 10, 100, 1000, 500, 1);
    arm_tick();
    type_code(1'b0);
    quiet_tick(kdac_pkg::KEY_NONE);
    quiet_tick(8'h31);
    load_config(code_q, 50, 10, 100, 1000, 500, 7);
    clear_incorrect();
    type_code(1'b1);
    load_config(code_q, 50, 10, 100, 1000, 500, 0);
    quiet_tick(kdac_pkg::KEY_ENTER);
    quiet_tick(kdac_pkg::KEY_NONE);
  endtask

  // An all-zero code can never be typed, so wrong attempts pile up to the
  // saturation point and the keypad stays locked for the rest of the phase.
  task automatic test_zero_code_lockout();
    load_config(32'h0, any_temp(), $urandom_range(1, 1000), $urandom_range(1, 2000),
                $urandom_range(1, 2000), $urandom_range(1, 2000), 7);
    run_traffic_phase(100);
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_keypad();
    test_zero_blink_period();
    test_timer_saturation();
    test_random_traffic();
    test_wrong_code_blocking();
    test_zero_code_lockout();

    wait_idle();
    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
rtl/core/kdac_pkg.sv
rtl/core/kdac_cfg.sv
rtl/core/kdac_blink.sv
rtl/core/kdac_keypad.sv
rtl/core/keypad_disarmed_alarm_controller.sv
tb/tb_keypad_disarmed_alarm_controller.sv
